### src/tcc_pkg.sv
package tcc_pkg;

    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 32;
    localparam int TAB_WIDTH   = 4;
    localparam int MIN_COLS    = 5;
    localparam int MIN_ROWS    = 2;
    localparam int COLS_W      = $clog2(MAX_COLS + 1);
    localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd30;

    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;

    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SCROLL = 2'd2,
        OP_CURSOR = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        KIND_CLS = 2'd0,
        KIND_NL  = 2'd1,
        KIND_TAB = 2'd2,
        KIND_PUT = 2'd3
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  char_code;
        logic [4:0]  clear_rows;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

### src/tcc_if.sv
interface tcc_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;
    logic [4:0] clear_rows;

    modport source (output valid, output command, output char_code, output clear_rows,
                    input ready);
    modport sink (input valid, input command, input char_code, input clear_rows,
                  output ready);
endinterface

interface tcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op_kind;
    logic [4:0]  cell_row;
    logic [6:0]  cell_col;
    logic [7:0]  cell_char;
    logic [11:0] span_length;
    logic [11:0] cursor_address;
    logic        last;

    modport source (output valid, output op_kind, output cell_row, output cell_col,
                    output cell_char, output span_length, output cursor_address,
                    output last, input ready);
    modport sink (input valid, input op_kind, input cell_row, input cell_col,
                  input cell_char, input span_length, input cursor_address,
                  input last, output ready);
endinterface

interface tcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/tcc_front.sv
module tcc_front (
    input  logic           clk,
    input  logic           rst_n,
    tcc_req_if.sink        req,
    output tcc_pkg::head_t head,
    input  logic           pop
);

    tcc_pkg::item_t                 queue_reg [tcc_pkg::QUEUE_DEPTH];
    logic [tcc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tcc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tcc_pkg::QCNT_W-1:0]     count_reg;
    logic [tcc_pkg::QCNT_W-1:0]     count_next;
    logic                           accept;
    logic                           push;
    logic                           do_pop;
    tcc_pkg::item_t                 item_in;

    assign req.ready = (count_reg != tcc_pkg::QCNT_W'(tcc_pkg::QUEUE_DEPTH));
    assign accept    = req.valid && req.ready;
    // carriage return is swallowed here, it never reaches the back end
    assign push      = accept && !(req.command == tcc_pkg::CMD_PUT &&
                                   req.char_code == tcc_pkg::CHAR_CR);
    assign do_pop    = pop && (count_reg != '0);

    always_comb
    begin
        item_in.char_code  = req.char_code;
        item_in.clear_rows = req.clear_rows;
        if (req.command == tcc_pkg::CMD_CLEAR)
        begin
            item_in.kind = tcc_pkg::KIND_CLS;
        end
        else if (req.char_code == tcc_pkg::CHAR_LF)
        begin
            item_in.kind = tcc_pkg::KIND_NL;
        end
        else if (req.char_code == tcc_pkg::CHAR_TAB)
        begin
            item_in.kind = tcc_pkg::KIND_TAB;
        end
        else
        begin
            item_in.kind = tcc_pkg::KIND_PUT;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                if (wr_ptr_reg == tcc_pkg::QPTR_W'(tcc_pkg::QUEUE_DEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == tcc_pkg::QPTR_W'(tcc_pkg::QUEUE_DEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];

endmodule

### src/tcc_back.sv
module tcc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tcc_pkg::head_t head,
    output logic           pop,
    tcc_cfg_if.sink        cfg,
    tcc_rsp_if.source      rsp
);

    typedef enum logic [2:0] {
        S_NL_CLEAR,
        S_NL_SCROLL,
        S_NL_CURSOR,
        S_TAB_CLEAR,
        S_WRITE,
        S_CURSOR,
        S_CLS_CURSOR,
        S_CLS_SPAN
    } step_t;

    step_t       step_reg, step_next, step_first, step_cur;
    logic        active_reg, active_next;
    logic [4:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  cols_cfg_reg;
    logic [5:0]  rows_cfg_reg;

    logic        out_valid_reg;
    logic [1:0]  op_kind_reg, op_kind_next;
    logic [4:0]  cell_row_reg, cell_row_next;
    logic [6:0]  cell_col_reg, cell_col_next;
    logic [7:0]  cell_char_reg, cell_char_next;
    logic [11:0] span_length_reg, span_length_next;
    logic [11:0] cursor_address_reg, cursor_address_next;
    logic        last_reg, last_next;

    logic [tcc_pkg::COLS_W-1:0] eff_cols;
    logic [tcc_pkg::ROWS_W-1:0] eff_rows;
    logic [tcc_pkg::ROWS_W-1:0] scroll_row;
    logic [15:0]                cursor_addr_full;
    logic                       have_work, load_ok, fire;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (16'(cols_cfg_reg) < 16'(tcc_pkg::MIN_COLS))
        begin
            eff_cols = tcc_pkg::COLS_W'(tcc_pkg::MIN_COLS);
        end
        else if (16'(cols_cfg_reg) > 16'(tcc_pkg::MAX_COLS))
        begin
            eff_cols = tcc_pkg::COLS_W'(tcc_pkg::MAX_COLS);
        end
        else
        begin
            eff_cols = tcc_pkg::COLS_W'(cols_cfg_reg);
        end
        if (16'(rows_cfg_reg) < 16'(tcc_pkg::MIN_ROWS))
        begin
            eff_rows = tcc_pkg::ROWS_W'(tcc_pkg::MIN_ROWS);
        end
        else if (16'(rows_cfg_reg) > 16'(tcc_pkg::MAX_ROWS))
        begin
            eff_rows = tcc_pkg::ROWS_W'(tcc_pkg::MAX_ROWS);
        end
        else
        begin
            eff_rows = tcc_pkg::ROWS_W'(rows_cfg_reg);
        end
    end

    assign scroll_row       = eff_rows - tcc_pkg::ROWS_W'(2);
    assign cursor_addr_full = 16'(row_reg) * 16'(eff_cols) + 16'(col_reg);

    // first step of the item at the queue head, picked from the live cursor
    always_comb
    begin
        case (head.item.kind)
            tcc_pkg::KIND_CLS:
            begin
                step_first = S_CLS_CURSOR;
            end
            tcc_pkg::KIND_NL:
            begin
                step_first = S_NL_CLEAR;
            end
            tcc_pkg::KIND_TAB:
            begin
                if (16'(col_reg) + 16'(tcc_pkg::TAB_WIDTH) >= 16'(eff_cols))
                begin
                    step_first = S_NL_CLEAR;
                end
                else
                begin
                    step_first = S_TAB_CLEAR;
                end
            end
            default:
            begin
                if (16'(col_reg) >= 16'(eff_cols))
                begin
                    step_first = S_NL_CLEAR;
                end
                else
                begin
                    step_first = S_WRITE;
                end
            end
        endcase
    end

    assign have_work = active_reg || head.valid;
    assign load_ok   = !out_valid_reg || rsp.ready;
    assign fire      = have_work && load_ok;
    assign step_cur  = active_reg ? step_reg : step_first;

    always_comb
    begin
        step_next           = step_cur;
        row_next            = row_reg;
        col_next            = col_reg;
        op_kind_next        = tcc_pkg::OP_CURSOR;
        cell_row_next       = '0;
        cell_col_next       = '0;
        cell_char_next      = '0;
        span_length_next    = '0;
        cursor_address_next = '0;
        last_next           = 1'b0;
        case (step_cur)
            S_NL_CLEAR:
            begin
                op_kind_next  = tcc_pkg::OP_CLEAR;
                cell_row_next = row_reg;
                cell_col_next = col_reg[6:0];
                if (16'(col_reg) < 16'(eff_cols))
                begin
                    span_length_next = 12'(16'(eff_cols) - 16'(col_reg));
                end
                col_next = '0;
                if (16'(row_reg) >= 16'(scroll_row))
                begin
                    step_next = S_NL_SCROLL;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    step_next = S_NL_CURSOR;
                end
            end
            S_NL_SCROLL:
            begin
                op_kind_next = tcc_pkg::OP_SCROLL;
                row_next     = 5'(scroll_row);
                step_next    = S_NL_CURSOR;
            end
            S_NL_CURSOR:
            begin
                op_kind_next        = tcc_pkg::OP_CURSOR;
                cursor_address_next = cursor_addr_full[11:0];
                case (head.item.kind)
                    tcc_pkg::KIND_TAB:
                    begin
                        step_next = S_CURSOR;
                    end
                    tcc_pkg::KIND_PUT:
                    begin
                        step_next = S_WRITE;
                    end
                    default:
                    begin
                        last_next = 1'b1;
                    end
                endcase
            end
            S_TAB_CLEAR:
            begin
                op_kind_next     = tcc_pkg::OP_CLEAR;
                cell_row_next    = row_reg;
                cell_col_next    = col_reg[6:0];
                span_length_next = 12'(tcc_pkg::TAB_WIDTH) -
                                   12'(col_reg % tcc_pkg::TAB_WIDTH);
                col_next         = 8'((16'(col_reg) + 16'(tcc_pkg::TAB_WIDTH)) &
                                      ~16'(tcc_pkg::TAB_WIDTH - 1));
                step_next        = S_CURSOR;
            end
            S_WRITE:
            begin
                op_kind_next   = tcc_pkg::OP_WRITE;
                cell_row_next  = row_reg;
                cell_col_next  = col_reg[6:0];
                cell_char_next = head.item.char_code;
                col_next       = col_reg + 1'b1;
                step_next      = S_CURSOR;
            end
            S_CURSOR:
            begin
                op_kind_next        = tcc_pkg::OP_CURSOR;
                cursor_address_next = cursor_addr_full[11:0];
                last_next           = 1'b1;
            end
            S_CLS_CURSOR:
            begin
                // home cursor, address of row 0 column 0 is zero
                op_kind_next = tcc_pkg::OP_CURSOR;
                row_next     = '0;
                col_next     = '0;
                step_next    = S_CLS_SPAN;
            end
            default:
            begin
                op_kind_next     = tcc_pkg::OP_CLEAR;
                span_length_next = 12'(32'(head.item.clear_rows) * tcc_pkg::MAX_COLS);
                last_next        = 1'b1;
            end
        endcase
    end

    assign pop         = fire && last_next;
    assign active_next = fire ? !last_next : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg           <= S_CURSOR;
            active_reg         <= 1'b0;
            row_reg            <= '0;
            col_reg            <= '0;
            cols_cfg_reg       <= tcc_pkg::COLS_RESET;
            rows_cfg_reg       <= tcc_pkg::ROWS_RESET;
            out_valid_reg      <= 1'b0;
            op_kind_reg        <= '0;
            cell_row_reg       <= '0;
            cell_col_reg       <= '0;
            cell_char_reg      <= '0;
            span_length_reg    <= '0;
            cursor_address_reg <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    tcc_pkg::REG_COLS:
                    begin
                        cols_cfg_reg <= cfg.data;
                    end
                    tcc_pkg::REG_ROWS:
                    begin
                        rows_cfg_reg <= cfg.data[5:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (load_ok)
            begin
                out_valid_reg <= fire;
            end
            if (fire)
            begin
                step_reg           <= step_next;
                active_reg         <= active_next;
                row_reg            <= row_next;
                col_reg            <= col_next;
                op_kind_reg        <= op_kind_next;
                cell_row_reg       <= cell_row_next;
                cell_col_reg       <= cell_col_next;
                cell_char_reg      <= cell_char_next;
                span_length_reg    <= span_length_next;
                cursor_address_reg <= cursor_address_next;
                last_reg           <= last_next;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.op_kind        = op_kind_reg;
    assign rsp.cell_row       = cell_row_reg;
    assign rsp.cell_col       = cell_col_reg;
    assign rsp.cell_char      = cell_char_reg;
    assign rsp.span_length    = span_length_reg;
    assign rsp.cursor_address = cursor_address_reg;
    assign rsp.last           = last_reg;

endmodule

### src/text_console_cursor_engine.sv
// Text console cursor engine. Each request beat (put character or clear screen) turns into
// two to five text-buffer operations on rsp, one beat per cycle unless rsp stalls, the final
// one flagged by last; carriage return produces nothing. The front end classifies requests
// into a two-entry queue, so it keeps taking beats while the queue has room and the back end
// sequencer works; the sequencer emits one operation per cycle into an output register while rsp is ready (a
// newline with scroll on a wrapped character is the longest item, at five operations). The
// cursor address is row times visible columns plus column, computed in the same cycle.
// Configuration writes (index 0 columns, 1 rows) are always ready and must be made while idle.
module text_console_cursor_engine (
    input  logic      clk,
    input  logic      rst_n,
    tcc_req_if.sink   req,
    tcc_rsp_if.source rsp,
    tcc_cfg_if.sink   cfg
);

    tcc_pkg::head_t head;
    logic           pop;

    tcc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    tcc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .cfg   (cfg),
        .rsp   (rsp)
    );

endmodule
